>>> src/cpr_pkg.sv
// Package of types, constants and helpers shared by the clock page replacement block.
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int NUM_PROCS  = 64;
    localparam int NUM_PAGES  = 64;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int FCNT_W  = $clog2(NUM_FRAMES + 1);
    localparam int STORE_W = $clog2(NUM_PROCS * NUM_PAGES);
    localparam int STORE_DEPTH = NUM_PROCS * NUM_PAGES;
    localparam int CFG_W   = 7;
    localparam int ID_W    = 6;

    localparam logic       CMD_ACCESS = 1'b0;
    localparam logic       CMD_FAULT  = 1'b1;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_DISK = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] frame_index;
        logic            is_write;
        logic [ID_W-1:0] process;
        logic [ID_W-1:0] page;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] chosen_frame;
        logic            evicted;
        logic [ID_W-1:0] victim_process;
        logic [ID_W-1:0] victim_page;
        logic            write_back;
        logic [1:0]      fill_action;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] page;
    } t_meta;

    typedef struct packed {
        logic [STORE_W-1:0] rd_addr;
        logic               disk_we;
        logic [STORE_W-1:0] disk_waddr;
        logic               touch_we;
        logic [STORE_W-1:0] touch_waddr;
    } t_st_ctl;

    typedef struct packed {
        logic busy;
        logic on_disk;
        logic touched;
    } t_st_stat;

    function automatic logic [STORE_W-1:0] store_index(input logic [ID_W-1:0] proc,
                                                       input logic [ID_W-1:0] pg);
        int idx;
        idx = (int'(proc) % NUM_PROCS) * NUM_PAGES + (int'(pg) % NUM_PAGES);
        return STORE_W'(idx);
    endfunction

endpackage

>>> src/clock_page_replacement_top.sv
// Top level of the clock (second-chance) page frame allocator.
// The input channel takes one request per item: an access report (cmd 0) marks a
// used, managed frame referenced, and dirty on a write; a page fault (cmd 1) asks
// for a frame for a (process, page) pair. The output channel returns one result
// per request with the frame, any displaced page and the fill action.
// An access report goes from acceptance straight to S_DONE, where its result is
// registered. A fault scans the frame-used bits one frame a cycle, and when every
// managed frame is in use the clock hand then sweeps one frame a cycle.
// One request is worked on at a time; the next can be accepted in the cycle after
// the previous result is registered, even while that result still waits.
// After reset the page store is cleared one entry a cycle, all 4096 entries,
// and no request is accepted meanwhile; the frame count register may be
// written at any time the block is idle. If the receiver stalls, the finished
// result is held and the sequencer waits before delivering the following one.
`timescale 1ns / 1ps

module clock_page_replacement_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  cpr_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output cpr_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_VREAD = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                         r_state;
    logic [cpr_pkg::CFG_W-1:0]          r_cfg;
    logic [cpr_pkg::NUM_FRAMES-1:0]     r_used;
    logic [cpr_pkg::NUM_FRAMES-1:0]     r_ref;
    logic [cpr_pkg::NUM_FRAMES-1:0]     r_dirty;
    logic [cpr_pkg::FRAME_W-1:0]        r_hand;
    logic [cpr_pkg::FRAME_W-1:0]        r_idx;
    logic [cpr_pkg::FRAME_W-1:0]        r_h;
    cpr_pkg::t_in                       r_req;
    cpr_pkg::t_out                      r_res;
    cpr_pkg::t_out                      r_out;
    logic                               r_out_valid;
    cpr_pkg::t_meta                     r_meta_mem [cpr_pkg::NUM_FRAMES];
    cpr_pkg::t_meta                     r_meta_q;

    logic [cpr_pkg::FCNT_W-1:0]         f;
    logic [cpr_pkg::FRAME_W-1:0]        n_h;
    logic                               idx_last;
    logic [cpr_pkg::FRAME_W-1:0]        sweep_start;
    logic                               accept;
    cpr_pkg::t_st_ctl                   st_ctl;
    cpr_pkg::t_st_stat                  st_stat;

    always_comb begin
        if (r_cfg == '0) begin
            f = cpr_pkg::FCNT_W'(1);
        end else if (int'(r_cfg) > cpr_pkg::NUM_FRAMES) begin
            f = cpr_pkg::FCNT_W'(cpr_pkg::NUM_FRAMES);
        end else begin
            f = cpr_pkg::FCNT_W'(r_cfg);
        end
    end

    assign n_h = ((cpr_pkg::FCNT_W'(r_h) + 1'b1) == f) ? '0 : r_h + 1'b1;
    assign idx_last = (cpr_pkg::FCNT_W'(r_idx) + 1'b1) == f;
    assign sweep_start = (cpr_pkg::FCNT_W'(r_hand) >= f) ? '0 : r_hand;

    assign o_ready = (r_state == S_IDLE) && !st_stat.busy;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign st_ctl.rd_addr     = cpr_pkg::store_index(r_req.process, r_req.page);
    assign st_ctl.disk_we     = (r_state == S_VREAD) && r_dirty[r_h];
    assign st_ctl.disk_waddr  = cpr_pkg::store_index(r_meta_q.owner, r_meta_q.page);
    assign st_ctl.touch_we    = (r_state == S_FILL) && !st_stat.on_disk && !st_stat.touched;
    assign st_ctl.touch_waddr = st_ctl.rd_addr;

    cpr_page_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .o_stat  (st_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cpr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ALLOC) begin
            r_meta_mem[r_res.chosen_frame] <= '{owner: r_req.process, page: r_req.page};
        end
        r_meta_q <= r_meta_mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_ref       <= '0;
            r_dirty     <= '0;
            r_hand      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_data;
                        r_idx <= '0;
                        if (i_data.cmd == cpr_pkg::CMD_ACCESS) begin
                            r_res <= '{chosen_frame: i_data.frame_index, evicted: 1'b0,
                                       victim_process: '0, victim_page: '0,
                                       write_back: 1'b0, fill_action: cpr_pkg::FILL_NONE};
                            if ((cpr_pkg::FCNT_W'(i_data.frame_index) < f)
                                && r_used[i_data.frame_index]) begin
                                r_ref[i_data.frame_index] <= 1'b1;
                                if (i_data.is_write) begin
                                    r_dirty[i_data.frame_index] <= 1'b1;
                                end
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_used[r_idx]) begin
                        r_res.chosen_frame <= r_idx;
                        r_state <= S_ALLOC;
                    end else if (idx_last) begin
                        r_h     <= sweep_start;
                        r_state <= S_SWEEP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (!r_ref[r_h]) begin
                        r_res.chosen_frame <= r_h;
                        r_hand  <= n_h;
                        r_state <= S_VREAD;
                    end else begin
                        r_ref[r_h] <= 1'b0;
                        r_h <= n_h;
                    end
                end
                S_VREAD: begin
                    r_res.evicted        <= 1'b1;
                    r_res.victim_process <= r_meta_q.owner;
                    r_res.victim_page    <= r_meta_q.page;
                    r_res.write_back     <= r_dirty[r_h];
                    r_state <= S_ALLOC;
                end
                S_ALLOC: begin
                    r_used[r_res.chosen_frame]  <= 1'b1;
                    r_ref[r_res.chosen_frame]   <= 1'b0;
                    r_dirty[r_res.chosen_frame] <= 1'b0;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (st_stat.on_disk) begin
                        r_res.fill_action <= cpr_pkg::FILL_DISK;
                    end else if (!st_stat.touched) begin
                        r_res.fill_action <= cpr_pkg::FILL_ZERO;
                    end else begin
                        r_res.fill_action <= cpr_pkg::FILL_NONE;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_stat.busy |-> !accept)
        else $error("request accepted during page store clearing");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (cpr_pkg::FCNT_W'(r_res.chosen_frame) < f))
        else $error("allocated frame beyond the managed frames");

    a_alloc_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> r_used[$past(r_res.chosen_frame)])
        else $error("allocated frame not marked used");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.write_back || r_out.evicted))
        else $error("write-back flagged without an eviction");

endmodule

>>> src/cpr_page_store.sv
// Per-page touched and on-disk stores with the clearing pass after reset.
`timescale 1ns / 1ps

module cpr_page_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpr_pkg::t_st_ctl  i_ctl,
    output cpr_pkg::t_st_stat o_stat
);

    logic r_disk_mem  [cpr_pkg::STORE_DEPTH];
    logic r_touch_mem [cpr_pkg::STORE_DEPTH];
    logic r_disk_q;
    logic r_touch_q;
    logic r_busy;
    logic [cpr_pkg::STORE_W-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == cpr_pkg::STORE_W'(cpr_pkg::STORE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_disk_mem[r_clr_idx] <= 1'b0;
        end else if (i_ctl.disk_we) begin
            r_disk_mem[i_ctl.disk_waddr] <= 1'b1;
        end
        r_disk_q <= r_disk_mem[i_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_touch_mem[r_clr_idx] <= 1'b0;
        end else if (i_ctl.touch_we) begin
            r_touch_mem[i_ctl.touch_waddr] <= 1'b1;
        end
        r_touch_q <= r_touch_mem[i_ctl.rd_addr];
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.on_disk = r_disk_q;
    assign o_stat.touched = r_touch_q;

endmodule
